### src/shil_pkg.sv
// Shared types and constants for the sorted hit insertion list.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package shil_pkg;

  localparam int POS_W = 24;
  localparam int OFF_W = 8;
  localparam int RID_W = 16;
  localparam int IDX_W = 6;
  localparam int HCNT_W = 7;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BEYOND = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [OFF_W-1:0] off;
    logic [RID_W-1:0] rid;
  } hit_entry_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_idx;
    logic shift_wr;
    logic new_wr;
    logic out_load;
  } shil_cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_read;
    logic op_ok;
    logic slot_zero;
    logic slot_one;
    logic gt;
    logic out_free;
  } shil_stat_t;

endpackage

`default_nettype wire

### src/sorted_hit_insert_list.sv
// Sorted hit insertion list: hits kept in ascending order of reference position.
// An operation is taken on the in_ channel and answered with one transaction on
// the out_ channel. The controller sequences the datapath, which holds a hit
// memory of CAPACITY entries, the hit count and the output register.
// Insert shifts larger entries up one place at a time, reading and comparing the
// entry below the free slot, then writes the new hit; equal positions keep arrival
// order. Every hit memory access uses its one read and one write port.
// Insert into a full list, read beyond the count, clear and an unused code leave
// the memory untouched; a read within the count makes one memory read.
// One operation is in progress at a time; in_stall is high from the accepting edge
// until its result is loaded into the output register, and the next operation can
// be taken at the edge after that. A new operation is taken while an earlier
// result still waits there; a stalled receiver holds the output register, and the
// block then waits before loading the next result.
// Synchronous reset empties the list and drops any pending result; the stored
// hits are not cleared and are reachable again only after being written.
`default_nettype none

module sorted_hit_insert_list
  import shil_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [FUNC_W-1:0]    in_func,
  input  wire [POS_W-1:0]     in_hit_position,
  input  wire [OFF_W-1:0]     in_hit_offset,
  input  wire [RID_W-1:0]     in_hit_read,
  input  wire [IDX_W-1:0]     in_entry_index,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [STAT_W-1:0]   out_status,
  output logic [HCNT_W-1:0]   out_hit_count,
  output logic [POS_W-1:0]    out_position,
  output logic [OFF_W-1:0]    out_offset,
  output logic [RID_W-1:0]    out_read
);

  shil_cmd_t  cmd;
  shil_stat_t stat;

  shil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  shil_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_func         (in_func),
    .in_hit_position (in_hit_position),
    .in_hit_offset   (in_hit_offset),
    .in_hit_read     (in_hit_read),
    .in_entry_index  (in_entry_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_hit_count   (out_hit_count),
    .out_position    (out_position),
    .out_offset      (out_offset),
    .out_read        (out_read)
  );

endmodule

`default_nettype wire

### src/shil_ctrl.sv
// Controller state machine of the sorted hit insertion list.
// Sequences the datapath through shared commands; depends on shil_pkg.
`default_nettype none

module shil_ctrl
  import shil_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  shil_stat_t stat,
  output shil_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_INS_RD   = 7'b0000100,
    S_INS_CMP  = 7'b0001000,
    S_INS_WR   = 7'b0010000,
    S_RD_MEM   = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_insert && stat.op_ok) begin
          state_nxt = stat.slot_zero ? S_INS_WR : S_INS_RD;
        end else if (stat.is_read && stat.op_ok) begin
          state_nxt = S_RD_MEM;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_INS_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_INS_CMP;
      end
      S_INS_CMP: begin
        if (stat.gt) begin
          cmd.shift_wr = 1'b1;
          state_nxt = stat.slot_one ? S_INS_WR : S_INS_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.new_wr = 1'b1;
        state_nxt = S_DONE;
      end
      S_RD_MEM: begin
        cmd.rd_en = 1'b1;
        cmd.rd_idx = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/shil_dpath.sv
// Datapath of the sorted hit insertion list: hit memory, count, operand and
// output registers. Driven by shil_ctrl; depends on shil_pkg.
`default_nettype none

module shil_dpath
  import shil_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  shil_cmd_t               cmd,
  output shil_stat_t              stat,
  input  wire [FUNC_W-1:0]        in_func,
  input  wire [POS_W-1:0]         in_hit_position,
  input  wire [OFF_W-1:0]         in_hit_offset,
  input  wire [RID_W-1:0]         in_hit_read,
  input  wire [IDX_W-1:0]         in_entry_index,
  output logic                    out_valid,
  input  wire                     out_stall,
  output logic [STAT_W-1:0]       out_status,
  output logic [HCNT_W-1:0]       out_hit_count,
  output logic [POS_W-1:0]        out_position,
  output logic [OFF_W-1:0]        out_offset,
  output logic [RID_W-1:0]        out_read
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  hit_entry_t mem [CAPACITY];

  logic [CW-1:0]     count_r;
  logic [CW-1:0]     slot_r;
  logic [FUNC_W-1:0] func_r;
  logic [STAT_W-1:0] status_r;
  logic [IDX_W-1:0]  idx_r;
  hit_entry_t        hit_r;
  hit_entry_t        q_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [HCNT_W-1:0] out_count_r;
  hit_entry_t        out_hit_r;

  logic [STAT_W-1:0] status_nxt;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  hit_entry_t        wr_data;
  logic              wr_en;

  always_comb begin
    status_nxt = STAT_OK;
    if (in_func == FUNC_INSERT && count_r == CAP_C) begin
      status_nxt = STAT_FULL;
    end else if (in_func == FUNC_READ && XW'(in_entry_index) >= XW'(count_r)) begin
      status_nxt = STAT_BEYOND;
    end
  end

  assign rd_addr = cmd.rd_idx ? IW'(idx_r) : IW'(slot_r - CW'(1));
  assign wr_addr = IW'(slot_r);
  assign wr_data = cmd.shift_wr ? q_r : hit_r;
  assign wr_en   = cmd.shift_wr || cmd.new_wr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.load && in_func == FUNC_CLEAR) begin
      count_r <= '0;
    end else if (cmd.new_wr) begin
      count_r <= count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r       <= in_func;
      status_r     <= status_nxt;
      idx_r        <= in_entry_index;
      hit_r.pos    <= in_hit_position;
      hit_r.off    <= in_hit_offset;
      hit_r.rid    <= in_hit_read;
      slot_r       <= count_r;
    end else if (cmd.shift_wr) begin
      slot_r <= slot_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= status_r;
      out_count_r  <= HCNT_W'(count_r);
      out_hit_r    <= (func_r == FUNC_READ && status_r == STAT_OK) ? q_r : '0;
    end
  end

  assign stat.is_insert = (func_r == FUNC_INSERT);
  assign stat.is_read   = (func_r == FUNC_READ);
  assign stat.op_ok     = (status_r == STAT_OK);
  assign stat.slot_zero = (slot_r == '0);
  assign stat.slot_one  = (slot_r == CW'(1));
  assign stat.gt        = (q_r.pos > hit_r.pos);
  assign stat.out_free  = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit_count = out_count_r;
  assign out_position  = out_hit_r.pos;
  assign out_offset    = out_hit_r.off;
  assign out_read      = out_hit_r.rid;

endmodule

`default_nettype wire

### tb/sorted_hit_insert_list_tb.sv
// Self-checking testbench for the sorted hit insertion list: directed and random
// insert, read and clear transactions, checked against an in-bench list predictor.
// Depends on shil_pkg and sorted_hit_insert_list only.
module sorted_hit_insert_list_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import shil_pkg::*;

  localparam int CAPACITY = 64;
  localparam int CLK_PERIOD = 10;
  localparam int HOLDOFF_CYCLES = 200;
  localparam int TAIL_CYCLES = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    hit_entry_t        hit;
    logic [IDX_W-1:0]  idx;
  } list_op_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [HCNT_W-1:0] hit_count;
    hit_entry_t        hit;
  } list_answer_t;

  class hit_list_model;
    hit_entry_t hits[CAPACITY];
    int stored;
    int fail_count;
    list_answer_t expected_answers[$];

    function new();
      stored = 0;
      fail_count = 0;
    endfunction

    function void report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      fail_count++;
    endfunction

    function void predict_op(list_op_t op);
      list_answer_t ans;
      int slot;
      ans = '0;
      case (op.func)
        FUNC_INSERT: begin
          if (stored >= CAPACITY) begin
            ans.status = STAT_FULL;
          end else begin
            slot = stored;
            while (slot > 0 && hits[slot-1].pos > op.hit.pos) begin
              hits[slot] = hits[slot-1];
              slot--;
            end
            hits[slot] = op.hit;
            stored++;
          end
        end
        FUNC_READ: begin
          if (op.idx >= stored) begin
            ans.status = STAT_BEYOND;
          end else begin
            ans.hit = hits[op.idx];
          end
        end
        FUNC_CLEAR: begin
          stored = 0;
        end
        default: begin
        end
      endcase
      ans.hit_count = HCNT_W'(stored);
      expected_answers.push_back(ans);
    endfunction

    function void check_answer(list_answer_t got);
      list_answer_t want;
      if (expected_answers.size() == 0) begin
        report($sformatf("unexpected result: status %0d count %0d", got.status,
                         got.hit_count));
        return;
      end
      want = expected_answers.pop_front();
      if (got.status !== want.status)
        report($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.hit_count !== want.hit_count)
        report($sformatf("hit_count %0d, expected %0d", got.hit_count, want.hit_count));
      if (got.hit.pos !== want.hit.pos)
        report($sformatf("position %0h, expected %0h", got.hit.pos, want.hit.pos));
      if (got.hit.off !== want.hit.off)
        report($sformatf("offset %0h, expected %0h", got.hit.off, want.hit.off));
      if (got.hit.rid !== want.hit.rid)
        report($sformatf("read id %0h, expected %0h", got.hit.rid, want.hit.rid));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] in_func;
  logic [POS_W-1:0]  in_hit_position;
  logic [OFF_W-1:0]  in_hit_offset;
  logic [RID_W-1:0]  in_hit_read;
  logic [IDX_W-1:0]  in_entry_index;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [HCNT_W-1:0] out_hit_count;
  logic [POS_W-1:0]  out_position;
  logic [OFF_W-1:0]  out_offset;
  logic [RID_W-1:0]  out_read;

  hit_list_model sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int holdoff_reqs = 0;
  int holdoffs_served = 0;
  int holdoff_left = 0;

  sorted_hit_insert_list #(
    .CAPACITY(CAPACITY)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_func(in_func),
    .in_hit_position(in_hit_position),
    .in_hit_offset(in_hit_offset),
    .in_hit_read(in_hit_read),
    .in_entry_index(in_entry_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_hit_count(out_hit_count),
    .out_position(out_position),
    .out_offset(out_offset),
    .out_read(out_read)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // A requested hold-off keeps the output stalled for a long stretch, so that
  // the block fills up and stalls its input.
  always @(negedge clk) begin
    if (holdoff_reqs != holdoffs_served) begin
      holdoffs_served = holdoff_reqs;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      out_stall = 1'b1;
      holdoff_left--;
    end else begin
      out_stall = ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_answer({out_status, out_hit_count, out_position, out_offset, out_read});
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  function automatic list_op_t make_op(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                       logic [OFF_W-1:0] off, logic [RID_W-1:0] rid,
                                       logic [IDX_W-1:0] idx);
    list_op_t op;
    op.func = func;
    op.hit.pos = pos;
    op.hit.off = off;
    op.hit.rid = rid;
    op.idx = idx;
    return op;
  endfunction

  function automatic logic [POS_W-1:0] random_position();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return POS_W'($urandom_range(0, 15));
      4: return POS_W'($urandom_range(0, 4095));
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic list_op_t random_op(bit filling);
    list_op_t op;
    int r;
    op = make_op(FUNC_READ, random_position(), OFF_W'($urandom), RID_W'($urandom),
                 IDX_W'($urandom));
    r = $urandom_range(0, 99);
    if (filling)
      op.func = (r < 80) ? FUNC_INSERT : FUNC_READ;
    else if (r < 2)
      op.func = FUNC_UNUSED;
    else if (r < 5)
      op.func = FUNC_CLEAR;
    else if (r < 58)
      op.func = FUNC_INSERT;
    if (op.func == FUNC_READ && sb.stored > 0 && $urandom_range(0, 3) != 0)
      op.idx = IDX_W'($urandom_range(0, sb.stored - 1));
    return op;
  endfunction

  task automatic send_op(list_op_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_func = op.func;
    in_hit_position = op.hit.pos;
    in_hit_offset = op.hit.off;
    in_hit_read = op.hit.rid;
    in_entry_index = op.idx;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.predict_op(op);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.expected_answers.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    send_op(make_op(FUNC_READ, '0, '0, '0, '0));
    send_op(make_op(FUNC_CLEAR, '0, '0, '0, '0));
    send_op(make_op(FUNC_UNUSED, '1, '1, '1, '1));
    send_op(make_op(FUNC_INSERT, '1, '1, '1, '0));
    send_op(make_op(FUNC_INSERT, '0, '0, '0, '1));
    send_op(make_op(FUNC_INSERT, 24'd100, 8'hA5, 16'h1234, '0));
    send_op(make_op(FUNC_INSERT, 24'd100, 8'h5A, 16'h4321, '0));
    send_op(make_op(FUNC_INSERT, 24'd100, 8'h0F, 16'hBEEF, '0));
    send_op(make_op(FUNC_INSERT, '0, 8'h11, 16'h0011, '0));
    send_op(make_op(FUNC_INSERT, '1, 8'h22, 16'h0022, '0));
    for (int i = 0; i < 7; i++)
      send_op(make_op(FUNC_READ, '0, '0, '0, IDX_W'(i)));
    send_op(make_op(FUNC_READ, '0, '0, '0, IDX_W'(7)));
    send_op(make_op(FUNC_READ, '0, '0, '0, '1));
    send_op(make_op(FUNC_UNUSED, '0, '0, '0, '0));
    send_op(make_op(FUNC_CLEAR, '1, '1, '1, '1));
    send_op(make_op(FUNC_READ, '0, '0, '0, '0));
    send_op(make_op(FUNC_INSERT, 24'd5, 8'h80, 16'h8000, '0));
    send_op(make_op(FUNC_READ, '0, '0, '0, '0));
  endtask

  // Segments either fill the list and push a few inserts past full, or mix
  // operations at random; a clear often follows a segment.
  task automatic run_random(int n_ops);
    int sent;
    int seg_len;
    int extra;
    bit filling;
    list_op_t op;
    sent = 0;
    while (sent < n_ops) begin
      filling = ($urandom_range(0, 2) == 0);
      seg_len = $urandom_range(8, 40);
      extra = $urandom_range(1, 3);
      while (sent < n_ops && (filling ? extra > 0 : seg_len > 0)) begin
        op = random_op(filling);
        if (filling && sb.stored >= CAPACITY && op.func == FUNC_INSERT)
          extra--;
        send_op(op);
        sent++;
        seg_len--;
      end
      if (sent < n_ops && $urandom_range(0, 2) == 0) begin
        send_op(make_op(FUNC_CLEAR, random_position(), OFF_W'($urandom), RID_W'($urandom),
                        IDX_W'($urandom)));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_INSERT;
    in_hit_position = '0;
    in_hit_offset = '0;
    in_hit_read = '0;
    in_entry_index = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (phase == 0) begin
        run_random(60);
        holdoff_reqs++;
        run_random(65);
      end else begin
        run_random(125);
      end
    end
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.expected_answers.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_answers.size()));
    if (sb.fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
